FILE: rtl/tpsc_pkg.sv
// Shared types and constants for the period-measuring tachometer core.
package tpsc_pkg;

    // Fixed field widths
    localparam int MIN_TICKS_W = 16;
    localparam int SPEED_W     = 32;
    localparam int DPP_W       = 20;
    localparam int DIST_W      = 52;
    localparam int TOTAL_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int OPCODE_W    = 2;

    // Register reset values
    localparam logic [MIN_TICKS_W-1:0] MIN_TICKS_RST = 16'd80;
    localparam logic [SPEED_W-1:0]     SPEED_K_RST   = 32'd7665485;
    localparam logic [DPP_W-1:0]       DPP_RST       = 20'd125591;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_K   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DPP       = 2'd2;

    // Item opcodes
    typedef enum logic [OPCODE_W-1:0] {
        OP_CAPTURE     = 2'd0,
        OP_CLEAR_COUNT = 2'd1,
        OP_CLEAR_ALL   = 2'd2
    } opcode_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_CALC = 1'b1
    } state_t;

    // Handshake between the sequencer and a serial arithmetic unit
    typedef struct packed {
        logic start;
    } unit_ctrl_t;

    typedef struct packed {
        logic busy;
    } unit_stat_t;

endpackage

FILE: rtl/tachometer_period_speed_core.sv
// Top level of the period-measuring tachometer: control, state and output register.
//
// Channel   Dir  Fields (low bit first)
// s_axis    in   tuser: opcode[1:0]; tdata: ticks[TICK_WIDTH-1:0], zero pad
// m_axis    out  tuser: accepted; tdata: speed_q8[31:0], distance_q16[83:32],
//                pulse_total[115:84], zero pad[119:116]
// cfg       in   index: register number; data: value (low bits used)
//
// An item runs from one input transfer to the next as follows. The count updates
// at the input transfer, then up to max(32, COUNT_WIDTH) serial steps follow, set by the
// radix-2 divider (only for an accepted capture with nonzero ticks) and the shift-add
// multiplier that run side by side, then the output register is loaded once it is free.
// Reset clears speed and count and restores the register defaults.
// The next item is taken as soon as a result is loaded; a stalled result
// holds back only the loading of the following one.
module tachometer_period_speed_core #(
    parameter int TICK_WIDTH  = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((TICK_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // ticks
    input  logic [tpsc_pkg::OPCODE_W-1:0]       s_axis_tuser,  // opcode
    // Result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [119:0]                        m_axis_tdata,  // speed, distance, total
    output logic                                m_axis_tuser,  // accepted
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tpsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tpsc_pkg::*;

    localparam int CMP_W  = (TICK_WIDTH > MIN_TICKS_W) ? TICK_WIDTH : MIN_TICKS_W;
    localparam int PROD_W = COUNT_WIDTH + DPP_W;

    // Configuration registers
    logic [MIN_TICKS_W-1:0] tick_floor_reg;
    logic [SPEED_W-1:0]     speed_k_reg;
    logic [DPP_W-1:0]       dpp_reg;

    // Block state
    state_t                 state_reg, state_next;
    logic [SPEED_W-1:0]     speed_reg, speed_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   acc_reg, acc_next;
    logic                   pend_reg, pend_next;

    // Output register
    logic                   out_valid_reg;
    logic [119:0]           out_data_reg;
    logic                   out_user_reg;

    // Unit interfaces
    unit_ctrl_t             div_ctrl, mul_ctrl;
    unit_stat_t             div_stat, mul_stat;
    logic [SPEED_W-1:0]     quotient;
    logic [PROD_W-1:0]      product;

    logic [TICK_WIDTH-1:0]  ticks;
    opcode_t                opcode;
    logic                   in_xfer;
    logic                   out_free;
    logic                   load;
    logic                   passes;
    logic [SPEED_W-1:0]     speed_out;

    assign ticks    = s_axis_tdata[TICK_WIDTH-1:0];
    assign opcode   = opcode_t'(s_axis_tuser);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign passes   = (CMP_W'(ticks) >= CMP_W'(tick_floor_reg));
    assign speed_out = pend_reg ? quotient : speed_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_floor_reg <= MIN_TICKS_RST;
            speed_k_reg    <= SPEED_K_RST;
            dpp_reg        <= DPP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN_TICKS: tick_floor_reg <= cfg_data[MIN_TICKS_W-1:0];
                CFG_SPEED_K:   speed_k_reg    <= cfg_data[SPEED_W-1:0];
                CFG_DPP:       dpp_reg        <= cfg_data[DPP_W-1:0];
                default:       ;
            endcase
        end
    end

    // Sequencer: decode the item, start the units, wait, load the result
    always_comb
    begin
        state_next    = state_reg;
        speed_next    = speed_reg;
        count_next    = count_reg;
        acc_next      = acc_reg;
        pend_next     = pend_reg;
        div_ctrl.start = 1'b0;
        mul_ctrl.start = 1'b0;
        load          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    acc_next  = 1'b0;
                    pend_next = 1'b0;
                    case (opcode)
                        OP_CAPTURE:
                        begin
                            if (passes)
                            begin
                                acc_next = 1'b1;
                                if (count_reg != '1)
                                begin
                                    count_next = count_reg + 1'b1;
                                end
                                if (ticks == '0)
                                begin
                                    speed_next = '0;
                                end
                                else
                                begin
                                    pend_next      = 1'b1;
                                    div_ctrl.start = 1'b1;
                                end
                            end
                        end
                        OP_CLEAR_COUNT:
                        begin
                            count_next = '0;
                        end
                        OP_CLEAR_ALL:
                        begin
                            count_next = '0;
                            speed_next = '0;
                        end
                        default: ;
                    endcase
                    mul_ctrl.start = 1'b1;
                    state_next     = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (!div_stat.busy && !mul_stat.busy && out_free)
                begin
                    load       = 1'b1;
                    speed_next = speed_out;
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            speed_reg <= '0;
            count_reg <= '0;
            acc_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            speed_reg <= speed_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            pend_reg  <= pend_next;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= {4'b0, TOTAL_W'(count_reg), DIST_W'(product), speed_out};
            out_user_reg <= acc_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // Speed: speed constant over ticks
    tpsc_divider #(
        .DIVISOR_W (TICK_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (speed_k_reg),
        .divisor  (ticks),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // Distance: updated count times distance per pulse
    tpsc_multiplier #(
        .COUNT_W (COUNT_WIDTH)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mul_ctrl),
        .count   (count_next),
        .dpp     (dpp_reg),
        .stat    (mul_stat),
        .product (product)
    );

endmodule

FILE: rtl/tpsc_divider.sv
// Radix-2 restoring divider: one quotient bit per cycle, speed constant by ticks.
module tpsc_divider #(
    parameter int DIVISOR_W = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tpsc_pkg::unit_ctrl_t          ctrl,
    input  logic [tpsc_pkg::SPEED_W-1:0]  dividend,
    input  logic [DIVISOR_W-1:0]          divisor,
    output tpsc_pkg::unit_stat_t          stat,
    output logic [tpsc_pkg::SPEED_W-1:0]  quotient
);
    import tpsc_pkg::*;

    localparam int CNT_W = $clog2(SPEED_W + 1);

    logic [DIVISOR_W-1:0] div_reg;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [SPEED_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 qbit;

    // One restoring step: bring down the next dividend bit, try to subtract
    always_comb
    begin
        trial    = {rem_reg, quo_reg[SPEED_W-1]};
        diff     = trial - {1'b0, div_reg};
        qbit     = (trial >= {1'b0, div_reg});
        rem_next = qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        quo_next = {quo_reg[SPEED_W-2:0], qbit};
    end

    // Step counter and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(SPEED_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: dividend shifts out of the top as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign quotient  = quo_reg;

endmodule

FILE: rtl/tpsc_multiplier.sv
// Shift-add multiplier: one count bit per cycle times the distance per pulse.
module tpsc_multiplier #(
    parameter int COUNT_W = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tpsc_pkg::unit_ctrl_t              ctrl,
    input  logic [COUNT_W-1:0]                count,
    input  logic [tpsc_pkg::DPP_W-1:0]        dpp,
    output tpsc_pkg::unit_stat_t              stat,
    output logic [COUNT_W+tpsc_pkg::DPP_W-1:0] product
);
    import tpsc_pkg::*;

    localparam int CNT_W = $clog2(COUNT_W + 1);

    logic [DPP_W-1:0]   dpp_reg;
    logic [DPP_W-1:0]   hi_reg;
    logic [COUNT_W-1:0] lo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic [DPP_W:0]     sum;

    // Add the multiplicand when the current count bit is set
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, dpp_reg} : '0);

    // Step counter and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(COUNT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Partial product shifts right into the spent count bits
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            dpp_reg <= dpp;
            hi_reg  <= '0;
            lo_reg  <= count;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[DPP_W:1];
            lo_reg <= {sum[0], lo_reg[COUNT_W-1:1]};
        end
    end

    assign stat.busy = busy_reg;
    assign product   = {hi_reg, lo_reg};

endmodule

FILE: bench/tachometer_period_speed_checker.sv
// Checker for the tachometer core: tracks register writes, predicts each result and compares.
module tachometer_period_speed_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,   // ticks
    input  logic [tpsc_pkg::OPCODE_W-1:0]   s_axis_tuser,   // opcode
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [119:0]                    m_axis_tdata,   // speed, distance, total
    input  logic                            m_axis_tuser,   // accepted
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [tpsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpsc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              results_seen,
    output int                              errors
);
    import tpsc_pkg::*;

    typedef struct packed {
        logic [31:0] speed;
        logic [51:0] distance;
        logic [31:0] total;
        logic        acc;
    } tach_result_t;

    // Mirror of the block's registers and state
    logic [15:0]  tick_floor;
    logic [31:0]  speed_k;
    logic [19:0]  dist_per_pulse;
    logic [31:0]  speed;
    logic [31:0]  pulse_count;

    tach_result_t pending_results[$];
    tach_result_t got;
    tach_result_t want;
    int           n_bad;

    // Apply one item to the mirrored state and return the result it produces
    function automatic tach_result_t advance_tach(input logic [1:0] op, input logic [15:0] ticks);
        tach_result_t r;
        r.acc = 1'b0;
        case (op)
            OP_CAPTURE:
                if (ticks >= tick_floor)
                begin
                    r.acc = 1'b1;
                    if (pulse_count != '1)
                        pulse_count = pulse_count + 32'd1;
                    // zero ticks gives speed zero instead of a division by zero
                    speed = (ticks == '0) ? '0 : speed_k / {16'd0, ticks};
                end
            OP_CLEAR_COUNT:
                pulse_count = '0;
            OP_CLEAR_ALL:
            begin
                pulse_count = '0;
                speed       = '0;
            end
            default: ;  // reserved opcode: no change
        endcase
        r.speed    = speed;
        r.distance = 52'(pulse_count) * 52'(dist_per_pulse);
        r.total    = pulse_count;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_floor     = MIN_TICKS_RST;
            speed_k        = SPEED_K_RST;
            dist_per_pulse = DPP_RST;
            speed          = '0;
            pulse_count    = '0;
            pending_results.delete();
            results_seen <= 0;
            errors       <= 0;
        end
        else
        begin
            n_bad = 0;

            // Register writes
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_MIN_TICKS: tick_floor     = cfg_data[15:0];
                    CFG_SPEED_K:   speed_k        = cfg_data;
                    CFG_DPP:       dist_per_pulse = cfg_data[19:0];
                    default: ;
                endcase

            // Input transfer: predict
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(advance_tach(s_axis_tuser, s_axis_tdata));

            // Output transfer: compare with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.speed    = m_axis_tdata[31:0];
                got.distance = m_axis_tdata[83:32];
                got.total    = m_axis_tdata[115:84];
                got.acc      = m_axis_tuser;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result: speed %h distance %h total %h accepted %b",
                             $time, got.speed, got.distance, got.total, got.acc);
                    n_bad = 1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.speed !== want.speed)
                    begin
                        $display("%0t: speed expected %h got %h", $time, want.speed, got.speed);
                        n_bad++;
                    end
                    if (got.distance !== want.distance)
                    begin
                        $display("%0t: distance expected %h got %h",
                                 $time, want.distance, got.distance);
                        n_bad++;
                    end
                    if (got.total !== want.total)
                    begin
                        $display("%0t: pulse total expected %h got %h",
                                 $time, want.total, got.total);
                        n_bad++;
                    end
                    if (got.acc !== want.acc)
                    begin
                        $display("%0t: accepted expected %b got %b", $time, want.acc, got.acc);
                        n_bad++;
                    end
                end
                results_seen <= results_seen + 1;
            end
            errors <= errors + n_bad;
        end
    end

endmodule

FILE: bench/tachometer_period_speed_core_tb.sv
// Testbench top for the tachometer core: clock, reset, stimulus and verdict.
module tachometer_period_speed_core_tb;
    import tpsc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    // the opcode field leaves one code unused; the block must ignore it
    localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;   // ticks
    logic [OPCODE_W-1:0]   s_axis_tuser = '0;   // opcode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [119:0]          m_axis_tdata;        // speed, distance, total, pad
    logic                  m_axis_tuser;        // accepted
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int          results_seen;
    int          errors;
    int          items_sent = 0;
    int          src_idle = 0;
    int          sink_stall = 0;
    int          cycle_count = 0;
    logic [15:0] cur_min = MIN_TICKS_RST;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    tachometer_period_speed_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    tachometer_period_speed_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .results_seen  (results_seen),
        .errors        (errors)
    );

    // Result side back-pressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall);

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // One input transfer, with a random gap ahead of it
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [15:0] ticks);
        if ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= ticks;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    // Stop sending and wait for every result to come back
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Back-to-back writes of all three registers; the block must be idle
    task automatic write_regs(input logic [15:0] mt, input logic [31:0] k,
                              input logic [19:0] dpp);
        cfg_valid <= 1'b1;
        put_reg(CFG_MIN_TICKS, {16'd0, mt});
        put_reg(CFG_SPEED_K, k);
        put_reg(CFG_DPP, {12'd0, dpp});
        cfg_valid <= 1'b0;
        cur_min = mt;
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin src_idle = 0;  sink_stall <= 0;  end
            1: begin src_idle = 49; sink_stall <= 0;  end
            2: begin src_idle = 0;  sink_stall <= 49; end
            default: begin src_idle = 22; sink_stall <= 22; end
        endcase
    endtask

    initial
    begin
        int          ph;
        int          n;
        int          r;
        logic [15:0] t;
        logic [1:0]  op;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset register values: threshold edges, clears, reserved code
        send_item(OP_CAPTURE, 16'd80);
        send_item(OP_CAPTURE, 16'd79);
        send_item(OP_CAPTURE, 16'hFFFF);
        send_item(OP_CAPTURE, 16'd1000);
        send_item(OP_CLEAR_COUNT, 16'hFFFF);
        send_item(OP_CAPTURE, 16'd81);
        send_item(OP_CLEAR_ALL, 16'd0);
        send_item(OP_RESERVED, 16'd500);
        send_item(OP_CAPTURE, 16'd0);
        drain();

        // Directed, widest constants and no threshold: zero ticks, largest quotient
        write_regs(16'd0, 32'hFFFF_FFFF, 20'hF_FFFF);
        send_item(OP_CAPTURE, 16'd0);
        send_item(OP_CAPTURE, 16'd1);
        send_item(OP_CAPTURE, 16'd2);
        send_item(OP_CAPTURE, 16'hFFFF);
        send_item(OP_RESERVED, 16'hFFFF);
        send_item(OP_CLEAR_COUNT, 16'd0);
        send_item(OP_CAPTURE, 16'd3);
        send_item(OP_CLEAR_ALL, 16'hFFFF);
        drain();

        // Directed, highest threshold and zero constants
        write_regs(16'hFFFF, 32'd0, 20'd0);
        send_item(OP_CAPTURE, 16'hFFFE);
        send_item(OP_CAPTURE, 16'hFFFF);
        send_item(OP_CLEAR_COUNT, 16'd7);
        send_item(OP_CAPTURE, 16'hFFFF);
        send_item(OP_CLEAR_ALL, 16'd9);
        send_item(OP_RESERVED, 16'd0);
        drain();

        // Random phases, each with its own register setting and one of four idle patterns
        for (ph = 0; ph < 8; ph++)
        begin
            drain();
            case (ph)
                0: write_regs(16'd0, 32'hFFFF_FFFF, 20'hF_FFFF);
                3: write_regs(16'd1, 32'd1, 20'd1);
                5: write_regs(16'($urandom_range(20000)), $urandom, 20'($urandom));
                default: write_regs(16'($urandom_range(400)), $urandom, 20'($urandom));
            endcase
            set_idle(ph % 4);
            for (n = 0; n < 200; n++)
            begin
                r = $urandom_range(99);
                if (r < 84)
                    op = OP_CAPTURE;
                else if (r < 91)
                    op = OP_CLEAR_COUNT;
                else if (r < 96)
                    op = OP_CLEAR_ALL;
                else
                    op = OP_RESERVED;
                case ($urandom_range(9))
                    0, 1: t = cur_min + 16'($urandom_range(4)) - 16'd2;  // near threshold
                    2:    t = 16'($urandom_range(255));
                    3:    t = $urandom_range(1) ? 16'hFFFF : 16'd0;
                    4, 5, 6, 7: t = 16'($urandom_range(16'hFFFF, cur_min));
                    default: t = 16'($urandom);
                endcase
                send_item(op, t);
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
